// File: design/rgbyc_pkg.sv
// Shared constants, coefficients and pipeline control type for the RGB/YUV converter.
package rgbyc_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int CK_BITS = 16;

	localparam int FPW = 27;
	localparam int IPW = 39;

	localparam logic REG_DIRECTION  = 1'b0;
	localparam logic REG_COLOR_MODE = 1'b1;

	localparam logic signed [17:0] KY_R = 18'sd19595;
	localparam logic signed [17:0] KY_G = 18'sd38470;
	localparam logic signed [17:0] KY_B = 18'sd7471;
	localparam logic signed [17:0] KU_R = -18'sd9643;
	localparam logic signed [17:0] KU_G = -18'sd18931;
	localparam logic signed [17:0] KU_B = 18'sd28574;
	localparam logic signed [17:0] KV_R = 18'sd40303;
	localparam logic signed [17:0] KV_G = -18'sd33749;
	localparam logic signed [17:0] KV_B = -18'sd6554;

	localparam logic signed [18:0] KR_V = 19'sd74703;
	localparam logic signed [18:0] KG_U = -19'sd25863;
	localparam logic signed [18:0] KG_V = -19'sd38052;
	localparam logic signed [18:0] KB_U = 19'sd133173;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
		logic dir_s2;
		logic mode_s2;
	} pipe_ctl_t;

	function automatic logic [7:0] clamp_byte(input logic signed [IPW-1:0] x);
		logic [7:0] r;
		if (x < 0)
			r = 8'd0;
		else if (x > 255)
			r = 8'd255;
		else
			r = x[7:0];
		return r;
	endfunction

endpackage

// File: design/rgbyc_fwd.sv
// Forward datapath: RGB bytes to fixed-point Y, U, V over three stages.
module rgbyc_fwd
	import rgbyc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  pipe_ctl_t           ctl,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic [15:0]         luma,
	output logic signed [15:0]  chroma_u,
	output logic signed [16:0]  chroma_v
);

	localparam int SH = CK_BITS - FRAC_BITS;
	localparam logic signed [FPW-1:0] RND = FPW'((1 << SH) >> 1);

	logic signed [FPW-1:0] p_yr_s1, p_yg_s1, p_yb_s1;
	logic signed [FPW-1:0] p_ur_s1, p_ug_s1, p_ub_s1;
	logic signed [FPW-1:0] p_vr_s1, p_vg_s1, p_vb_s1;
	logic [7:0]            red_s1;

	logic signed [FPW-1:0] y_s2, u_s2, v_s2;
	logic [7:0]            red_s2;

	logic signed [FPW-1:0] y_r, u_r, v_r;
	logic [23:0]           grey_w;

	logic [15:0]           luma_s3;
	logic signed [15:0]    chroma_u_s3;
	logic signed [16:0]    chroma_v_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			p_yr_s1 <= $signed({1'b0, red})   * KY_R;
			p_yg_s1 <= $signed({1'b0, green}) * KY_G;
			p_yb_s1 <= $signed({1'b0, blue})  * KY_B;
			p_ur_s1 <= $signed({1'b0, red})   * KU_R;
			p_ug_s1 <= $signed({1'b0, green}) * KU_G;
			p_ub_s1 <= $signed({1'b0, blue})  * KU_B;
			p_vr_s1 <= $signed({1'b0, red})   * KV_R;
			p_vg_s1 <= $signed({1'b0, green}) * KV_G;
			p_vb_s1 <= $signed({1'b0, blue})  * KV_B;
			red_s1  <= red;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			y_s2   <= p_yr_s1 + p_yg_s1 + p_yb_s1;
			u_s2   <= p_ur_s1 + p_ug_s1 + p_ub_s1;
			v_s2   <= p_vr_s1 + p_vg_s1 + p_vb_s1;
			red_s2 <= red_s1;
		end
	end

	always_comb begin
		y_r    = (y_s2 + RND) >>> SH;
		u_r    = (u_s2 + RND) >>> SH;
		v_r    = (v_s2 + RND) >>> SH;
		grey_w = 24'(red_s2) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			if (ctl.dir_s2) begin
				luma_s3     <= '0;
				chroma_u_s3 <= '0;
				chroma_v_s3 <= '0;
			end else if (!ctl.mode_s2) begin
				luma_s3     <= grey_w[15:0];
				chroma_u_s3 <= '0;
				chroma_v_s3 <= '0;
			end else begin
				luma_s3     <= y_r[15:0];
				chroma_u_s3 <= u_r[15:0];
				chroma_v_s3 <= v_r[16:0];
			end
		end
	end

	assign luma     = luma_s3;
	assign chroma_u = chroma_u_s3;
	assign chroma_v = chroma_v_s3;

endmodule

// File: design/rgbyc_inv.sv
// Inverse datapath: fixed-point Y, U, V to clamped RGB bytes over three stages.
module rgbyc_inv
	import rgbyc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  pipe_ctl_t           ctl,
	input  logic signed [19:0]  luma,
	input  logic signed [19:0]  chroma_u,
	input  logic signed [19:0]  chroma_v,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);

	localparam int SHI = FRAC_BITS + CK_BITS;
	localparam logic signed [20:0] GRND = 21'((1 << FRAC_BITS) >> 1);

	logic signed [IPW-1:0] ys_s1, p_rv_s1, p_gu_s1, p_gv_s1, p_bu_s1;
	logic signed [19:0]    luma_s1;

	logic signed [IPW-1:0] r_s2, g_s2, b_s2;
	logic signed [20:0]    grey_s2;

	logic signed [IPW-1:0] r_sh, g_sh, b_sh;

	logic [7:0] red_s3, green_s3, blue_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			ys_s1   <= IPW'(luma) <<< CK_BITS;
			p_rv_s1 <= chroma_v * KR_V;
			p_gu_s1 <= chroma_u * KG_U;
			p_gv_s1 <= chroma_v * KG_V;
			p_bu_s1 <= chroma_u * KB_U;
			luma_s1 <= luma;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			r_s2    <= ys_s1 + p_rv_s1;
			g_s2    <= ys_s1 + p_gu_s1 + p_gv_s1;
			b_s2    <= ys_s1 + p_bu_s1;
			grey_s2 <= (21'(luma_s1) + GRND) >>> FRAC_BITS;
		end
	end

	always_comb begin
		r_sh = r_s2 >>> SHI;
		g_sh = g_s2 >>> SHI;
		b_sh = b_s2 >>> SHI;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			if (!ctl.dir_s2) begin
				red_s3   <= '0;
				green_s3 <= '0;
				blue_s3  <= '0;
			end else if (!ctl.mode_s2) begin
				red_s3   <= clamp_byte(IPW'(grey_s2));
				green_s3 <= '0;
				blue_s3  <= '0;
			end else begin
				red_s3   <= clamp_byte(r_sh);
				green_s3 <= clamp_byte(g_sh);
				blue_s3  <= clamp_byte(b_sh);
			end
		end
	end

	assign red   = red_s3;
	assign green = green_s3;
	assign blue  = blue_s3;

endmodule

// File: design/rgb_yuv_color_convert.sv
// Top level of the pipelined RGB/YUV colour converter with configuration registers.
//
// channel   signals                                  transfer when
// -------   --------------------------------------   ---------------------------
// input     in_valid, in_stall, 6 pixel fields      in_valid & !in_stall
// output    out_valid, out_stall, 6 result fields   out_valid & !out_stall
// config    wr_en, wr_index, wr_data                 wr_en
//
// The stages are multiply, sum, and round and clamp, each stage registered.
// One pixel enters per cycle while the output is taken; throughput is 1 per clock.
// A stall holds only the stages that are full; empty stages keep filling.
// Reset clears the stage valid bits and sets direction 0, colour mode 1.
module rgb_yuv_color_convert
	import rgbyc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic                wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	input  logic signed [19:0]  luma_in,
	input  logic signed [19:0]  chroma_u_in,
	input  logic signed [19:0]  chroma_v_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         luma_out,
	output logic signed [15:0]  chroma_u_out,
	output logic signed [16:0]  chroma_v_out,
	output logic [7:0]          red_out,
	output logic [7:0]          green_out,
	output logic [7:0]          blue_out
);

	logic direction_q, color_mode_q;
	logic v_s1, v_s2, v_s3;
	logic dir_s1, mode_s1, dir_s2, mode_s2;
	pipe_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b0;
			color_mode_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_DIRECTION:  direction_q  <= wr_data;
				REG_COLOR_MODE: color_mode_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl.adv3    = !v_s3 || !out_stall;
		ctl.adv2    = !v_s2 || ctl.adv3;
		ctl.adv1    = !v_s1 || ctl.adv2;
		ctl.dir_s2  = dir_s2;
		ctl.mode_s2 = mode_s2;
	end

	assign in_stall  = !ctl.adv1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ctl.adv1)
				v_s1 <= in_valid;
			if (ctl.adv2)
				v_s2 <= v_s1;
			if (ctl.adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			dir_s1  <= direction_q;
			mode_s1 <= color_mode_q;
		end
		if (ctl.adv2) begin
			dir_s2  <= dir_s1;
			mode_s2 <= mode_s1;
		end
	end

	rgbyc_fwd #(
		.FRAC_BITS(FRAC_BITS)
	) u_fwd (
		.clk      (clk),
		.ctl      (ctl),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.luma     (luma_out),
		.chroma_u (chroma_u_out),
		.chroma_v (chroma_v_out)
	);

	rgbyc_inv #(
		.FRAC_BITS(FRAC_BITS)
	) u_inv (
		.clk      (clk),
		.ctl      (ctl),
		.luma     (luma_in),
		.chroma_u (chroma_u_in),
		.chroma_v (chroma_v_in),
		.red      (red_out),
		.green    (green_out),
		.blue     (blue_out)
	);

endmodule
